// ===== rtl/core/irm_pkg.sv =====
// shared types and constants of the interval range map
package irm_pkg;

  // capacity of the range table
  localparam int unsigned MAX_RANGES = 64;
  // count of valid entries, 0 .. MAX_RANGES
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  // scratch fill count, 0 .. MAX_RANGES + 2
  localparam int unsigned FILL_W = $clog2(MAX_RANGES + 3);
  // table bank address, depth MAX_RANGES + 2
  localparam int unsigned ADDR_W = $clog2(MAX_RANGES + 2);
  localparam int unsigned DEPTH = MAX_RANGES + 2;

  // request kinds carried on in_tuser
  localparam logic REQ_FIND = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // one table entry: inclusive range and its owner
  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] stop_v;
    logic [31:0] start_v;
  } entry_t;

endpackage

// ===== rtl/core/interval_range_map.sv =====
// Sorted table of disjoint 32-bit ranges with owner ids. The table lives in two
// banks of synchronous RAM (one read port, one write port, registered read). A find
// request scans the active bank one entry at a time, a read then a check per entry.
// A set request streams the active bank through the trim, split and merge logic
// into the other bank (states RD, EV, PA, PB and PC per entry), then flips
// banks unless the new table would exceed capacity. One request is worked on at
// a time; the next is taken only once the last result has left the output register.
module interval_range_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] first_bound, [63:32] second_bound, [95:64] owner_id
  input  logic [95:0] in_tdata,
  // [0] req_type
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] found_id
  output logic [31:0] out_tdata,
  // [0] table_full
  output logic [0:0]  out_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EV, S_PA, S_PB, S_PC, S_FIN, S_FLUSH, S_CMT,
    S_FRD, S_FCK, S_DONE
  } state_t;

  state_t state_r;
  logic bank_r;
  logic [irm_pkg::CNT_W-1:0]  cnt_r, idx_r;
  logic [irm_pkg::FILL_W-1:0] m_r, m_nxt;
  logic [31:0] lo_r, hi_r, id_r;
  logic placed_r;
  logic pv_r, pv_nxt;
  irm_pkg::entry_t p_r, p_nxt, pa_r, pc_r, rd0_r, rd1_r, rdata, newp, push_x, wdata;
  logic fa_r, fb_r, fc_r;
  logic push_en, merge, wen;
  logic [irm_pkg::ADDR_W-1:0] waddr, raddr;
  logic out_tvalid_r;
  logic [31:0] res_found_r;
  logic res_full_r;
  logic lt, gt, ovr_hi;
  logic [31:0] a_in, b_in;

  irm_pkg::entry_t mem0 [irm_pkg::DEPTH];
  irm_pkg::entry_t mem1 [irm_pkg::DEPTH];

  assign in_tready  = (state_r == S_IDLE) && !out_tvalid_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = res_found_r;
  assign out_tuser  = res_full_r;

  assign a_in  = in_tdata[31:0];
  assign b_in  = in_tdata[63:32];
  assign rdata = bank_r ? rd1_r : rd0_r;
  assign newp  = '{owner: id_r, stop_v: hi_r, start_v: lo_r};
  assign raddr = irm_pkg::ADDR_W'(idx_r);

  // classify the entry just read against the set range
  assign lt     = rdata.stop_v < lo_r;
  assign gt     = rdata.start_v > hi_r;
  assign ovr_hi = !lt && !gt && (rdata.stop_v > hi_r);

  // piece to append to the scratch bank this cycle
  always_comb begin
    push_en = 1'b0;
    push_x  = pa_r;
    case (state_r)
      S_PA:  begin push_en = fa_r; push_x = pa_r; end
      S_PB:  begin push_en = fb_r; push_x = newp; end
      S_PC:  begin push_en = fc_r; push_x = pc_r; end
      S_FIN: begin push_en = !placed_r; push_x = newp; end
      default: begin push_en = 1'b0; push_x = pa_r; end
    endcase
  end

  // merge with the held piece or retire it into the scratch bank
  assign merge = pv_r && (p_r.owner == push_x.owner) && (p_r.stop_v != 32'hFFFF_FFFF) &&
                 (p_r.stop_v + 32'd1 == push_x.start_v);

  always_comb begin
    p_nxt  = p_r;
    pv_nxt = pv_r;
    m_nxt  = m_r;
    wen    = 1'b0;
    wdata  = p_r;
    waddr  = irm_pkg::ADDR_W'(m_r);
    if (state_r == S_IDLE) begin
      pv_nxt = 1'b0;
      m_nxt  = '0;
    end else if (push_en) begin
      if (merge) begin
        p_nxt.stop_v = push_x.stop_v;
      end else begin
        if (pv_r) begin
          wen   = 1'b1;
          m_nxt = m_r + 1'b1;
        end
        p_nxt  = push_x;
        pv_nxt = 1'b1;
      end
    end else if (state_r == S_FLUSH && pv_r) begin
      wen    = 1'b1;
      m_nxt  = m_r + 1'b1;
      pv_nxt = 1'b0;
    end
  end

  // table banks: read the active one, write the other
  always_ff @(posedge clk) begin
    if (wen && bank_r) begin
      mem0[waddr] <= wdata;
    end
    if (wen && !bank_r) begin
      mem1[waddr] <= wdata;
    end
    rd0_r <= mem0[raddr];
    rd1_r <= mem1[raddr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bank_r       <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
      m_r          <= '0;
      pv_r         <= 1'b0;
      placed_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      m_r  <= m_nxt;
      pv_r <= pv_nxt;
      p_r  <= p_nxt;
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            idx_r    <= '0;
            id_r     <= in_tdata[95:64];
            placed_r <= (in_tdata[95:64] == 32'd0);
            if (in_tuser[0] == irm_pkg::REQ_FIND) begin
              lo_r    <= a_in;
              state_r <= (cnt_r == '0) ? S_DONE : S_FRD;
              res_found_r <= 32'd0;
              res_full_r  <= 1'b0;
            end else begin
              lo_r    <= (a_in <= b_in) ? a_in : b_in;
              hi_r    <= (a_in <= b_in) ? b_in : a_in;
              state_r <= (cnt_r == '0) ? S_FIN : S_RD;
            end
          end
        end
        S_FRD: state_r <= S_FCK;
        S_FCK: begin
          if (lo_r >= rdata.start_v && lo_r <= rdata.stop_v) begin
            res_found_r <= rdata.owner;
            state_r     <= S_DONE;
          end else if (idx_r + 1'b1 >= cnt_r) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_FRD;
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          fa_r <= lt || (!gt && rdata.start_v < lo_r);
          pa_r <= lt ? rdata : '{owner: rdata.owner, stop_v: lo_r - 32'd1,
                                 start_v: rdata.start_v};
          fb_r <= !placed_r && (gt || ovr_hi);
          placed_r <= placed_r || gt || ovr_hi;
          fc_r <= gt || ovr_hi;
          pc_r <= gt ? rdata : '{owner: rdata.owner, stop_v: rdata.stop_v,
                                 start_v: hi_r + 32'd1};
          state_r <= S_PA;
        end
        S_PA: state_r <= S_PB;
        S_PB: state_r <= S_PC;
        S_PC: begin
          if (idx_r + 1'b1 >= cnt_r) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_FIN:   state_r <= S_FLUSH;
        S_FLUSH: state_r <= S_CMT;
        S_CMT: begin
          res_found_r <= 32'd0;
          if (m_r > irm_pkg::FILL_W'(irm_pkg::MAX_RANGES)) begin
            res_full_r <= 1'b1;
          end else begin
            res_full_r <= 1'b0;
            bank_r     <= !bank_r;
            cnt_r      <= irm_pkg::CNT_W'(m_r);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a rejected set never reports an owner
  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("full flag with nonzero id");

  // table count stays within capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= irm_pkg::CNT_W'(irm_pkg::MAX_RANGES))
    else $error("entry count over capacity");

  // scratch fill never passes its bank depth
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    m_r <= irm_pkg::FILL_W'(irm_pkg::DEPTH))
    else $error("scratch fill overflow");

  // banks flip only on a committed set
  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    bank_r != $past(bank_r) |-> $past(state_r) == S_CMT)
    else $error("bank flip outside commit");

endmodule
